/* src/ptla_pkg.sv */
// Shared types and constants for the peer table learn-and-age unit.
// No dependencies.
`default_nettype none
package ptla_pkg;

    localparam logic [31:0] IDLE_LIMIT_RESET_MS = 32'd30 * 32'd1000;

    typedef enum logic [2:0] {
        STS_HIT        = 3'd0,
        STS_LEARNED    = 3'd1,
        STS_FULL       = 3'd2,
        STS_EVICTED    = 3'd3,
        STS_SWEEP_DONE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_PACKET = 1'b0,
        OP_SWEEP  = 1'b1
    } t_op;

    typedef struct packed {
        logic [31:0] last_ms;
        logic [15:0] port;
        logic [31:0] ip;
    } t_entry;

    typedef struct packed {
        t_op         operation;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  entry_index;
        logic [31:0] entry_ip;
        logic [15:0] entry_port;
        logic        last_result;
    } t_result;

endpackage
`default_nettype wire

/* src/ptla_mem.sv */
// Entry store: one write port, one read port, registered read data.
// Depends on ptla_pkg for the entry layout.
`default_nettype none
module ptla_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  ptla_pkg::t_entry     i_wr_data,
    input  wire logic [AW-1:0]   i_rd_addr,
    output ptla_pkg::t_entry     o_rd_data
);
    import ptla_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* src/ptla_ctrl.sv */
// Slot scanner: walks the entry store one slot per cycle for lookup/learn and aging
// unless a result waits on the output. Depends on ptla_pkg; drives ptla_mem ports.
`default_nettype none
module ptla_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  ptla_pkg::t_item      i_item,
    output logic                 o_idle,
    input  wire logic [31:0]     i_idle_limit,
    input  wire logic            i_out_free,
    output logic                 o_res_valid,
    output ptla_pkg::t_result    o_res,
    output logic                 o_wr_en,
    output logic [IW-1:0]        o_wr_addr,
    output ptla_pkg::t_entry     o_wr_data,
    output logic [IW-1:0]        o_rd_addr,
    input  ptla_pkg::t_entry     i_rd_data
);
    import ptla_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state             r_state, n_state;
    logic [IW-1:0]      r_idx, n_idx;
    logic               r_free_found, n_free_found;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    t_item              r_item;

    logic               last;
    logic               hit;
    logic               evict;
    logic [31:0]        idle_ms;
    logic [3:0]         idx4;
    logic [3:0]         free4;
    logic [IW+3:0]      idx_ext;
    logic [IW+3:0]      free_ext;

    assign last     = (r_idx == LAST_IDX);
    assign hit      = r_valid[r_idx] && (i_rd_data.ip == r_item.peer_ip)
                      && (i_rd_data.port == r_item.peer_port);
    assign idle_ms  = r_item.now_ms - i_rd_data.last_ms;
    assign evict    = r_valid[r_idx] && (idle_ms > i_idle_limit);
    assign idx_ext  = (IW + 4)'(r_idx);
    assign idx4     = idx_ext[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        logic [IW-1:0] free_idx;
        logic          free_ok;
        free_idx     = r_free_found ? r_free_idx : r_idx;
        free_ok      = r_free_found || !r_valid[r_idx];
        free_ext     = (IW + 4)'(free_idx);
        free4        = free_ext[3:0];
        n_state      = r_state;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        o_idle       = 1'b0;
        o_rd_addr    = r_idx;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx;
        o_wr_data    = '{last_ms: r_item.now_ms, port: r_item.peer_port, ip: r_item.peer_ip};
        o_res_valid  = 1'b0;
        o_res        = '{status: STS_SWEEP_DONE, entry_index: 4'd0, entry_ip: 32'd0,
                         entry_port: 16'd0, last_result: 1'b1};
        unique case (r_state)
            S_IDLE: begin
                o_idle    = 1'b1;
                o_rd_addr = '0;
                if (i_start) begin
                    n_state      = S_SCAN;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_item.operation == OP_PACKET) begin
                    priority if (hit) begin
                        if (i_out_free) begin
                            o_wr_en     = 1'b1;
                            o_res_valid = 1'b1;
                            o_res       = '{status: STS_HIT, entry_index: idx4,
                                            entry_ip: r_item.peer_ip,
                                            entry_port: r_item.peer_port, last_result: 1'b1};
                            n_state     = S_IDLE;
                        end
                    end else if (last) begin
                        if (i_out_free) begin
                            o_res_valid = 1'b1;
                            n_state     = S_IDLE;
                            if (free_ok) begin
                                o_wr_en           = 1'b1;
                                o_wr_addr         = free_idx;
                                n_valid[free_idx] = 1'b1;
                                o_res = '{status: STS_LEARNED, entry_index: free4,
                                          entry_ip: r_item.peer_ip,
                                          entry_port: r_item.peer_port, last_result: 1'b1};
                            end else begin
                                o_res = '{status: STS_FULL, entry_index: 4'd0,
                                          entry_ip: r_item.peer_ip,
                                          entry_port: r_item.peer_port, last_result: 1'b1};
                            end
                        end
                    end else begin
                        if (!r_valid[r_idx] && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_idx;
                        end
                        n_idx     = r_idx + IW'(1);
                        o_rd_addr = n_idx;
                    end
                end else begin
                    if (!evict || i_out_free) begin
                        if (evict) begin
                            o_res_valid    = 1'b1;
                            o_res          = '{status: STS_EVICTED, entry_index: idx4,
                                               entry_ip: i_rd_data.ip,
                                               entry_port: i_rd_data.port, last_result: 1'b0};
                            n_valid[r_idx] = 1'b0;
                        end
                        if (last) begin
                            n_state = S_DONE;
                        end else begin
                            n_idx     = r_idx + IW'(1);
                            o_rd_addr = n_idx;
                        end
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/peer_table_learn_and_age_unit.sv */
// Top level of the peer table: stream ports, idle-limit register, result register.
// Depends on ptla_pkg, ptla_ctrl and ptla_mem.
//
//   channel  | signals                        | direction | transaction moves
//   ---------+--------------------------------+-----------+--------------------------
//   s_axis   | tvalid tready tdata tuser      | in        | one packet or sweep item
//   m_axis   | tvalid tready tdata tlast      | out       | one result
//   cfg      | i_cfg_valid o_cfg_ready data   | in        | idle_limit_ms write
//
// A packet item holds the unit from its accept cycle through a scan of the slots
// (a hit ends the scan early); a sweep holds it through a scan of every slot and
// the done state; both are held longer by output stalls, and both are set by the scan
// of one slot per cycle through the single read port of the entry store.
// Reset empties the table at once (per-slot valid flops) and loads 30000 ms.
// Hold the scan on a due result while the result register is full.
`default_nettype none
module peer_table_learn_and_age_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,   // peer_ip, peer_port, now_ms
    input  wire logic [0:0]  s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // status, entry_index, entry_ip, entry_port, pad
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);
    import ptla_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic          r_out_valid;
    t_result       r_out;
    logic [31:0]   r_idle_limit;

    t_item         item;
    logic          start;
    logic          idle;
    logic          out_free;
    logic          res_valid;
    t_result       res;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;

    assign item = '{operation: t_op'(s_axis_tuser[0]), peer_ip: s_axis_tdata[31:0],
                    peer_port: s_axis_tdata[47:32], now_ms: s_axis_tdata[79:48]};
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RESET_MS;
        end else if (i_cfg_valid) begin
            r_idle_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.entry_port, r_out.entry_ip, r_out.entry_index,
                            r_out.status};
    assign m_axis_tlast  = r_out.last_result;

    ptla_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (item),
        .o_idle       (idle),
        .i_idle_limit (r_idle_limit),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    ptla_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

/* test/peer_table_learn_and_age_unit_test.sv */
// Self-checking bench for peer_table_learn_and_age_unit: drives packet and sweep items
// over the stream ports, predicts each result from a shadow of the peer table.
// Depends on ptla_pkg and the unit under test.
`timescale 1ns / 100ps
`default_nettype none
module peer_table_learn_and_age_unit_test;
    import ptla_pkg::*;

    localparam int SLOTS = 16;
    localparam int POOL_KEYS = 24;
    localparam int PHASE_ITEMS = 66;

    class peer_table_shadow;
        bit          slot_used[SLOTS];
        bit [31:0]   slot_ip[SLOTS];
        bit [15:0]   slot_port[SLOTS];
        bit [31:0]   slot_seen_ms[SLOTS];
        bit [31:0]   idle_limit = IDLE_LIMIT_RESET_MS;
        t_result     pending[$];
        int          errors;
        int          n_items;
        int          n_sweeps;
        int          n_reports;
        int          n_hits;
        int          n_learned;
        int          n_full;
        int          n_evicted;

        function void predict(t_op op, bit [31:0] ip, bit [15:0] port, bit [31:0] now_v);
            int free_slot;
            bit [31:0] idle;
            free_slot = -1;
            n_items++;
            if (op == OP_PACKET) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        if (slot_ip[i] == ip && slot_port[i] == port) begin
                            slot_seen_ms[i] = now_v;
                            pending.push_back('{STS_HIT, 4'(i), ip, port, 1'b1});
                            n_hits++;
                            return;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (free_slot < 0) begin
                    pending.push_back('{STS_FULL, 4'd0, ip, port, 1'b1});
                    n_full++;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_ip[free_slot] = ip;
                    slot_port[free_slot] = port;
                    slot_seen_ms[free_slot] = now_v;
                    pending.push_back('{STS_LEARNED, 4'(free_slot), ip, port, 1'b1});
                    n_learned++;
                end
            end else begin
                n_sweeps++;
                for (int i = 0; i < SLOTS; i++) begin
                    idle = now_v - slot_seen_ms[i];
                    if (slot_used[i] && idle > idle_limit) begin
                        slot_used[i] = 1'b0;
                        pending.push_back('{STS_EVICTED, 4'(i), slot_ip[i], slot_port[i], 1'b0});
                        n_evicted++;
                    end
                end
                pending.push_back('{STS_SWEEP_DONE, 4'd0, 32'd0, 16'd0, 1'b1});
            end
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            n_reports++;
            if (pending.size() == 0) begin
                $error("unexpected result: status %0d index %0d ip 0x%0h port 0x%0h",
                       got.status, got.entry_index, got.entry_ip, got.entry_port);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare("status", 32'(want.status), 32'(got.status));
            compare("entry_index", 32'(want.entry_index), 32'(got.entry_index));
            compare("entry_ip", want.entry_ip, got.entry_ip);
            compare("entry_port", 32'(want.entry_port), 32'(got.entry_port));
            compare("last_result", 32'(want.last_result), 32'(got.last_result));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // peer_ip, peer_port, now_ms
    logic [0:0]  s_axis_tuser = '0;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // status, entry_index, entry_ip, entry_port, pad
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    peer_table_shadow table_shadow = new();
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;
    bit [31:0]   wall_ms;
    bit [31:0]   key_ip[POOL_KEYS];
    bit [15:0]   key_port[POOL_KEYS];
    bit [31:0]   phase_limits[5];

    peer_table_learn_and_age_unit #(.TABLE_ENTRIES(SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!receiver_stalls) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat (gap_len() + 1) @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            table_shadow.check_report('{t_status'(m_axis_tdata[2:0]), m_axis_tdata[6:3],
                                        m_axis_tdata[38:7], m_axis_tdata[54:39],
                                        m_axis_tlast});
        end
    end

    task automatic send_item(t_op op, bit [31:0] ip, bit [15:0] port, bit [31:0] now_v);
        int gap;
        gap = sender_gaps ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {now_v, port, ip};
        do @(posedge i_clk); while (!s_axis_tready);
        table_shadow.predict(op, ip, port, now_v);
    endtask

    task automatic wait_drained(int settle);
        s_axis_tvalid <= 1'b0;
        while (table_shadow.pending.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_idle_limit(bit [31:0] value);
        wait_drained(40);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        table_shadow.idle_limit = value;
    endtask

    task automatic run_phase(bit [31:0] limit);
        bit [31:0] step_cap;
        int        pick;
        int        k;
        step_cap = (limit > 32'h3FFF_FFFF) ? 32'h3FFF_FFFF : limit / 4 + 2;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) wall_ms = $urandom;
            else if (pick < 60) wall_ms += $urandom_range(0, step_cap);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_item(OP_SWEEP, $urandom, 16'($urandom_range(0, 65535)), wall_ms);
            end else if (pick < 22) begin
                send_item(OP_PACKET, $urandom, 16'($urandom_range(0, 65535)), wall_ms);
            end else begin
                k = $urandom_range(0, POOL_KEYS - 1);
                send_item(OP_PACKET, key_ip[k], key_port[k], wall_ms);
            end
        end
    endtask

    initial begin
        key_ip[0] = 32'h0;
        key_port[0] = 16'h0;
        key_ip[1] = 32'hFFFF_FFFF;
        key_port[1] = 16'hFFFF;
        for (int k = 2; k < POOL_KEYS; k++) begin
            key_ip[k] = $urandom;
            key_port[k] = 16'($urandom_range(0, 65535));
        end
        phase_limits = '{32'd0, 32'd5000, 32'hFFFF_FFFF, IDLE_LIMIT_RESET_MS, $urandom};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // learn, refresh, keep at the limit, evict just past it
        send_item(OP_PACKET, 32'h0, 16'h0, 32'd1000);
        send_item(OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 32'd1000);
        send_item(OP_PACKET, 32'h0, 16'h0, 32'd31000);
        send_item(OP_SWEEP, 32'h0, 16'h0, 32'd31000);
        send_item(OP_SWEEP, 32'hFFFF_FFFF, 16'hFFFF, 32'd31001);
        // fill the table, then overflow it
        for (int k = 2; k < 17; k++) begin
            send_item(OP_PACKET, key_ip[k], key_port[k], 32'd31000);
        end
        send_item(OP_PACKET, key_ip[17], key_port[17], 32'd31000);
        // time earlier than every entry wraps to a huge idle time
        send_item(OP_SWEEP, 32'h0, 16'h0, 32'd30999);
        send_item(OP_SWEEP, 32'h0, 16'h0, 32'hFFFF_FFFF);

        wall_ms = 32'hFFFF_0000;
        for (int p = 0; p < 5; p++) begin
            write_idle_limit(phase_limits[p]);
            sender_gaps = (p != 1);
            receiver_stalls = (p != 3);
            run_phase(phase_limits[p]);
        end

        wait_drained(60);
        $display("Ran %0d items (%0d sweeps) across idle limits 30000, 0, 5000, max, random.",
                 table_shadow.n_items, table_shadow.n_sweeps);
        $display("Checked %0d results: %0d hits, %0d learned, %0d full, %0d evictions.",
                 table_shadow.n_reports, table_shadow.n_hits, table_shadow.n_learned,
                 table_shadow.n_full, table_shadow.n_evicted);
        if (table_shadow.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
src/ptla_pkg.sv
src/ptla_mem.sv
src/ptla_ctrl.sv
src/peer_table_learn_and_age_unit.sv
test/peer_table_learn_and_age_unit_test.sv
